/* hw/rtl/mhq_pkg.sv */
// Package for the max-heap priority queue: widths, command codes and the
// control/status structs passed between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package mhq_pkg;

    localparam int unsigned DATA_W           = 32;
    localparam int unsigned COUNT_W          = 8;
    localparam int unsigned DEFAULT_CAPACITY = 128;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // transaction taken on the command channel
        logic reject;       // command refused (full on insert, empty on remove)
        logic ins_start;    // latch new value, open slot at the end
        logic rem_start;    // shrink count, read the last entry
        logic dn_load;      // take the last entry as the value to sift down
        logic up_read;      // read the parent of the current slot
        logic dn_read;      // read both children of the current slot
        logic move_up;      // copy parent down into the current slot
        logic move_down;    // copy larger child up into the current slot
        logic place;        // write the sifted value into the current slot
        logic load_result;  // capture the result fields
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;     // current slot is the root
        logic left_out;     // current slot has no children
        logic up_gt;        // sifted value beats its parent
        logic dn_gt;        // larger child beats the sifted value
    } dp_status_t;

endpackage

/* hw/rtl/mhq_cmd_if.sv */
// Command channel of the max-heap priority queue: valid/ready plus payload.
// Depends on mhq_pkg.
`timescale 1ns / 1ps

interface mhq_cmd_if;
    import mhq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

/* hw/rtl/mhq_res_if.sv */
// Result channel of the max-heap priority queue: valid/ready plus payload.
// Depends on mhq_pkg.
`timescale 1ns / 1ps

interface mhq_res_if;
    import mhq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  top_value;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_empty;
    logic                      is_full;
    logic                      rejected;

    modport source (output valid, output top_value, output item_count, output is_empty,
                    output is_full, output rejected, input ready);
    modport sink   (input valid, input top_value, input item_count, input is_empty,
                    input is_full, input rejected, output ready);
endinterface

/* hw/rtl/mhq_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128,
    localparam int unsigned AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr_a,
    input  logic [AddrW-1:0] raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

/* hw/rtl/mhq_datapath.sv */
// Datapath of the max-heap priority queue: heap RAM, fill count, slot pointer,
// sifted value, root copy and result registers. Depends on mhq_pkg, mhq_ram.
`timescale 1ns / 1ps

module mhq_datapath #(
    parameter int unsigned CAPACITY = mhq_pkg::DEFAULT_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mhq_pkg::ctl_cmd_t                 cmd,
    input  logic signed [mhq_pkg::DATA_W-1:0] value,
    output mhq_pkg::dp_status_t               status,
    output logic signed [mhq_pkg::DATA_W-1:0] top_value,
    output logic [mhq_pkg::COUNT_W-1:0]       item_count,
    output logic                              is_empty,
    output logic                              is_full,
    output logic                              rejected
);
    import mhq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = AW + 2;

    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] root_reg;
    logic              rej_reg;

    logic [DATA_W-1:0] rdata_a, rdata_b;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic              we;
    logic [DATA_W-1:0] wdata;

    logic [IW-1:0]     left_idx, right_idx, count_x;
    logic              right_in;
    logic [AW-1:0]     parent_idx;
    logic [CW-1:0]     count_m1;
    logic              pick_right;
    logic [DATA_W-1:0] pick_val;
    logic [AW-1:0]     pick_idx;

    assign count_x    = IW'(count_reg);
    assign left_idx   = IW'({pos_reg, 1'b1});
    assign right_idx  = left_idx + IW'(1);
    assign right_in   = right_idx < count_x;
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign count_m1   = count_reg - CW'(1);

    // Children arrive in the cycle after dn_read; pos is unchanged meanwhile
    assign pick_right = right_in && ($signed(rdata_b) > $signed(rdata_a));
    assign pick_val   = pick_right ? rdata_b : rdata_a;
    assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        if (cmd.rem_start)
        begin
            raddr_a = count_m1[AW-1:0];
        end
        else if (cmd.up_read)
        begin
            raddr_a = parent_idx;
        end
        else if (cmd.dn_read)
        begin
            raddr_a = left_idx[AW-1:0];
            raddr_b = right_in ? right_idx[AW-1:0] : left_idx[AW-1:0];
        end
    end

    assign we    = cmd.place | cmd.move_up | cmd.move_down;
    assign wdata = cmd.place ? val_reg : (cmd.move_up ? rdata_a : pick_val);

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        if (cmd.ins_start)
        begin
            count_next = count_reg + CW'(1);
            pos_next   = count_reg[AW-1:0];
            val_next   = value;
        end
        if (cmd.rem_start)
        begin
            count_next = count_m1;
        end
        if (cmd.dn_load)
        begin
            val_next = rdata_a;
            pos_next = '0;
        end
        if (cmd.move_up)
        begin
            pos_next = parent_idx;
        end
        if (cmd.move_down)
        begin
            pos_next = pick_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        if (cmd.accept)
        begin
            rej_reg <= cmd.reject;
        end
        // Track the root: every write to slot zero is the new maximum
        if (we && (pos_reg == '0))
        begin
            root_reg <= wdata;
        end
        if (cmd.load_result)
        begin
            top_value  <= (count_reg == '0) ? '0 : $signed(root_reg);
            item_count <= COUNT_W'(count_reg);
            is_empty   <= (count_reg == '0);
            is_full    <= (count_reg == CW'(CAPACITY));
            rejected   <= rej_reg;
        end
    end

    assign status.full     = (count_reg == CW'(CAPACITY));
    assign status.empty    = (count_reg == '0);
    assign status.pos_zero = (pos_reg == '0);
    assign status.left_out = (left_idx >= count_x);
    assign status.up_gt    = $signed(val_reg) > $signed(rdata_a);
    assign status.dn_gt    = $signed(pick_val) > $signed(val_reg);

    mhq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

endmodule

/* hw/rtl/mhq_controller.sv */
// Controller of the max-heap priority queue: sequences sift-up and sift-down
// and owns both handshakes. Depends on mhq_pkg.
`timescale 1ns / 1ps

module mhq_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_command,
    output logic                cmd_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  mhq_pkg::dp_status_t status,
    output mhq_pkg::ctl_cmd_t   ctl
);
    import mhq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CHK  = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LOAD = 3'd3;
    localparam logic [2:0] S_DN_CHK  = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.accept = 1'b1;
                    if (cmd_command == CMD_INSERT)
                    begin
                        if (status.full)
                        begin
                            ctl.reject = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.ins_start = 1'b1;
                            state_next    = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (status.empty)
                        begin
                            ctl.reject = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.rem_start = 1'b1;
                            state_next    = S_DN_LOAD;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (status.pos_zero)
                begin
                    ctl.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (status.up_gt)
                begin
                    ctl.move_up = 1'b1;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_LOAD:
            begin
                ctl.dn_load = 1'b1;
                state_next  = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (status.left_out)
                begin
                    ctl.place  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.dn_read = 1'b1;
                    state_next  = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (status.dn_gt)
                begin
                    ctl.move_down = 1'b1;
                    state_next    = S_DN_CHK;
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    ctl.load_result = 1'b1;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* hw/rtl/max_heap_priority_queue_core.sv */
// Binary max-heap priority queue. Each command transaction inserts a signed
// 32-bit value (command 0) or removes the maximum (command 1) and yields one
// result transaction carrying the maximum after the step (zero when empty),
// the item count, and the empty, full and rejected flags; an insert into a
// full heap or a remove from an empty heap changes nothing and is flagged
// rejected. Commands are handled one at a time. Each heap level is handled as
// a read step followed by a compare step: the read step issues a read of the
// heap RAM (parent, or both children through the second read port) and the
// compare step compares the registered read data and writes a slot. A refused
// command goes straight to the result. With the default capacity of 128 an
// insert climbs at most seven levels. The next command can be accepted in the
// same cycle as the result appears. The result register frees the command
// side: the next command is accepted as soon as the current one is captured
// there, even if the result is still waiting to be taken. The heap RAM is not
// cleared after reset; only slots below the count are ever read.
// Depends on mhq_pkg, mhq_cmd_if, mhq_res_if, mhq_ram, mhq_datapath,
// mhq_controller.
`timescale 1ns / 1ps

module max_heap_priority_queue_core #(
    parameter int unsigned CAPACITY = mhq_pkg::DEFAULT_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    mhq_cmd_if.sink    cmd,
    mhq_res_if.source  res
);
    import mhq_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t status;

    // Sequencer: decides what the datapath does each cycle, drives ready/valid
    mhq_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd.valid),
        .cmd_command (cmd.command),
        .cmd_ready   (cmd.ready),
        .res_valid   (res.valid),
        .res_ready   (res.ready),
        .status      (status),
        .ctl         (ctl)
    );

    // Heap storage, slot pointer and result registers
    mhq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl),
        .value      (cmd.value),
        .status     (status),
        .top_value  (res.top_value),
        .item_count (res.item_count),
        .is_empty   (res.is_empty),
        .is_full    (res.is_full),
        .rejected   (res.rejected)
    );

`ifndef ASSERT_OFF
    // A refused command only happens at the two boundaries
    a_reject_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.rejected |-> res.is_full || res.is_empty)
        else $error("rejected result without full or empty heap");

    // One command at a time: acceptance closes the command side
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while previous one in flight");

    // At most one heap write source per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.place, ctl.move_up, ctl.move_down}))
        else $error("conflicting heap writes");
`endif

endmodule

/* dv/max_heap_priority_queue_core_test.sv */
// Self-checking testbench for max_heap_priority_queue_core: drives command
// transactions, predicts each result with a local heap and checks every field.
// Depends on mhq_pkg, mhq_cmd_if, mhq_res_if and the core RTL.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_test;
    import mhq_pkg::*;

    localparam int unsigned HEAP_DEPTH  = DEFAULT_CAPACITY;
    localparam int          CLK_HALF    = 10;
    localparam int          RESET_CYCLES = 6;
    // Slowest case: the longest sift in the core plus long sender gaps and receiver
    // stalls per transaction; the limit leaves several times that margin.
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 32;

    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       item_count;
        logic                     is_empty;
        logic                     is_full;
        logic                     rejected;
    } heap_status_t;

    logic clk;
    logic rst_n;

    mhq_cmd_if cmd_ch ();
    mhq_res_if res_ch ();

    max_heap_priority_queue_core #(
        .CAPACITY (HEAP_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Local copy of the heap, advanced once per accepted command transaction.
    logic signed [DATA_W-1:0] model_heap [HEAP_DEPTH];
    int unsigned              model_fill;

    heap_status_t expected_status_q [$];

    int mismatch_count;
    int cycle_count;
    int sender_idle_pct;
    int sink_idle_pct;

    // Clock: 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Timeout: count cycles and end the run if the limit is reached.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[max_heap_priority_queue_core] ERROR");
        $finish;
    end

    // Apply one command to the local heap and return the status it leaves.
    function automatic heap_status_t apply_heap_command(input logic op,
                                                        input logic signed [DATA_W-1:0] val);
        heap_status_t             st;
        int unsigned              pos;
        int unsigned              parent;
        int unsigned              left;
        int unsigned              right;
        int unsigned              pick;
        logic signed [DATA_W-1:0] tmp;
        st.rejected = 1'b0;
        if (op == CMD_INSERT)
        begin
            if (model_fill >= HEAP_DEPTH)
            begin
                st.rejected = 1'b1;
            end
            else
            begin
                model_heap[model_fill] = val;
                model_fill++;
                pos = model_fill - 1;
                // Climb while strictly larger than the parent; ties stay put.
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!(model_heap[pos] > model_heap[parent]))
                        break;
                    tmp = model_heap[pos];
                    model_heap[pos] = model_heap[parent];
                    model_heap[parent] = tmp;
                    pos = parent;
                end
            end
        end
        else
        begin
            if (model_fill == 0)
            begin
                st.rejected = 1'b1;
            end
            else
            begin
                model_fill--;
                model_heap[0] = model_heap[model_fill];
                pos = 0;
                // Descend toward the larger child; left wins on a tie.
                forever
                begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    if (left >= model_fill)
                        break;
                    pick = left;
                    if (right < model_fill && model_heap[right] > model_heap[left])
                        pick = right;
                    if (!(model_heap[pick] > model_heap[pos]))
                        break;
                    tmp = model_heap[pick];
                    model_heap[pick] = model_heap[pos];
                    model_heap[pos] = tmp;
                    pos = pick;
                end
            end
        end
        st.top_value  = (model_fill > 0) ? model_heap[0] : '0;
        st.item_count = model_fill[COUNT_W-1:0];
        st.is_empty   = (model_fill == 0);
        st.is_full    = (model_fill >= HEAP_DEPTH);
        return st;
    endfunction

    // Mostly random words, with extremes and a narrow band that forces ties.
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2, 3: v = $signed(32'($urandom_range(0, 6))) - 32'sd3;
            default: v = $signed($urandom());
        endcase
        return v;
    endfunction

    task automatic set_idle(input int sender_pct, input int sink_pct);
        sender_idle_pct = sender_pct;
        sink_idle_pct   = sink_pct;
    endtask

    // Send one command transaction. Enter and leave on a falling edge; the
    // expectation is recorded at the rising edge that accepts the transaction.
    task automatic send_heap_command(input logic op, input logic signed [DATA_W-1:0] val);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct)
                @(negedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.value   <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expected_status_q.push_back(apply_heap_command(op, val));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint exp_val, input longint act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Receiver side: drop ready on the configured share of cycles.
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        heap_status_t exp_st;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                $error("result transaction with no pending expectation");
                mismatch_count++;
            end
            else
            begin
                exp_st = expected_status_q.pop_front();
                check_field("top_value", exp_st.top_value, res_ch.top_value);
                check_field("item_count", exp_st.item_count, res_ch.item_count);
                check_field("is_empty", exp_st.is_empty, res_ch.is_empty);
                check_field("is_full", exp_st.is_full, res_ch.is_full);
                check_field("rejected", exp_st.rejected, res_ch.rejected);
            end
        end
    end

    // Remove from an empty heap right after reset.
    task automatic test_empty_remove();
        send_heap_command(CMD_REMOVE, 32'sh1234_5678);
    endtask

    // Insert both signed extremes, zero and +/-1, then pull them all out in
    // order and run one more remove past empty.
    task automatic test_value_extremes();
        send_heap_command(CMD_INSERT, '0);
        send_heap_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_heap_command(CMD_INSERT, 32'sh8000_0000);
        send_heap_command(CMD_INSERT, -32'sd1);
        send_heap_command(CMD_INSERT, 32'sd1);
        repeat (5)
            send_heap_command(CMD_REMOVE, 32'sh8000_0000);
        send_heap_command(CMD_REMOVE, 32'sh7FFF_FFFF);
    endtask

    // Equal keys never swap; equal children resolve to the left one.
    task automatic test_ties();
        send_heap_command(CMD_INSERT, 32'sd5);
        send_heap_command(CMD_INSERT, 32'sd5);
        send_heap_command(CMD_INSERT, 32'sd5);
        send_heap_command(CMD_REMOVE, '0);
        send_heap_command(CMD_REMOVE, '0);
        send_heap_command(CMD_REMOVE, '0);
        send_heap_command(CMD_INSERT, 32'sd10);
        send_heap_command(CMD_INSERT, 32'sd4);
        send_heap_command(CMD_INSERT, 32'sd4);
        send_heap_command(CMD_INSERT, 32'sd1);
        repeat (4)
            send_heap_command(CMD_REMOVE, '0);
    endtask

    // Fill to capacity with random values, hit the full heap a few times and
    // toggle across the full boundary.
    task automatic test_fill_to_capacity();
        while (model_fill < HEAP_DEPTH)
            send_heap_command(CMD_INSERT, pick_value());
        repeat (3)
            send_heap_command(CMD_INSERT, pick_value());
        send_heap_command(CMD_REMOVE, pick_value());
        send_heap_command(CMD_INSERT, pick_value());
        send_heap_command(CMD_INSERT, pick_value());
    endtask

    // Drain to empty and keep removing past it.
    task automatic test_drain_to_empty();
        while (model_fill > 0)
            send_heap_command(CMD_REMOVE, pick_value());
        repeat (2)
            send_heap_command(CMD_REMOVE, pick_value());
    endtask

    // Random traffic in bursts, each with its own insert bias so the count
    // wanders across the whole range.
    task automatic test_mixed_traffic(input int n_items);
        int sent;
        int burst;
        int insert_pct;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0: insert_pct = 20;
                1: insert_pct = 50;
                2: insert_pct = 70;
                default: insert_pct = 90;
            endcase
            while (burst > 0 && sent < n_items)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                    send_heap_command(CMD_INSERT, pick_value());
                else
                    send_heap_command(CMD_REMOVE, pick_value());
                burst--;
                sent++;
            end
        end
    endtask

    initial
    begin
        // Hold every command input at a known value from time zero.
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_INSERT;
        cmd_ch.value    = '0;
        model_fill      = 0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        sink_idle_pct   = 0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver stalls heavily.
        set_idle(38, 76);
        test_empty_remove();
        test_value_extremes();
        test_ties();
        test_fill_to_capacity();
        test_mixed_traffic(100);

        // Swap the roles: slow sender, mostly ready receiver.
        set_idle(76, 38);
        test_drain_to_empty();
        test_mixed_traffic(150);

        // Back-to-back traffic on both sides.
        set_idle(0, 0);
        test_mixed_traffic(150);

        cmd_ch.valid <= 1'b0;

        // Wait for every outstanding result, then let the core settle.
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0)
            $display("[max_heap_priority_queue_core] OK");
        else
            $display("[max_heap_priority_queue_core] ERROR");
        $finish;
    end

endmodule
